[design/rrf_pkg.sv]
package rrf_pkg;

	localparam int unsigned FIELD_WIDTH = 64;
	localparam logic [7:0] RESET_DEPTH = 8'd16;

	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_RESIZE = 2'd2;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_FULL      = 3'd1;
	localparam logic [2:0] STAT_EMPTY     = 3'd2;
	localparam logic [2:0] STAT_RANGE     = 3'd3;
	localparam logic [2:0] STAT_BELOW_LOAD = 3'd4;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  load_now;
		logic [7:0]  depth_now;
		logic [31:0] pushed_total;
		logic [31:0] popped_total;
	} rrf_res_t;

endpackage

[design/rrf_mem.sv]
module rrf_mem #(
	parameter int unsigned ADDR_WIDTH = 8,
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_WIDTH-1:0] wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [ADDR_WIDTH-1:0] rd_addr,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [2**ADDR_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/rrf_ctrl.sv]
module rrf_ctrl #(
	parameter int unsigned MAX_DEPTH     = 128,
	parameter int unsigned PAYLOAD_WIDTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [7:0]                            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            in_req,
	input  logic [rrf_pkg::FIELD_WIDTH-1:0]       in_payload,
	input  logic [7:0]                            in_new_depth,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output rrf_pkg::rrf_res_t                     res,
	output logic [PAYLOAD_WIDTH-1:0]              res_payload,
	output logic                                  mem_wr_en,
	output logic [$clog2(MAX_DEPTH):0]            mem_wr_addr,
	output logic [PAYLOAD_WIDTH-1:0]              mem_wr_data,
	output logic                                  mem_rd_en,
	output logic [$clog2(MAX_DEPTH):0]            mem_rd_addr,
	input  logic [PAYLOAD_WIDTH-1:0]              mem_rd_data
);

	localparam int unsigned AW = $clog2(MAX_DEPTH);
	localparam int unsigned DW = $clog2(MAX_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COPY,
		ST_EMIT
	} state_t;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s, input logic [DW-1:0] d);
		logic [31:0] inc;
		inc = 32'(s) + 32'd1;
		return (inc >= 32'(d)) ? '0 : inc[AW-1:0];
	endfunction

	function automatic logic [DW-1:0] clamp_depth(input logic [7:0] v);
		if (v == 8'd0) begin
			return DW'(1);
		end
		if (32'(v) > MAX_DEPTH) begin
			return DW'(MAX_DEPTH);
		end
		return DW'(v);
	endfunction

	state_t          state_q;
	logic            bank_q;
	logic [AW-1:0]   rd_slot_q;
	logic [AW-1:0]   wr_slot_q;
	logic [DW-1:0]   fill_q;
	logic [DW-1:0]   depth_q;
	logic [31:0]     push_cnt_q;
	logic [31:0]     pop_cnt_q;
	logic [2:0]      status_q;
	logic            pop_ok_q;
	logic [DW-1:0]   nd_q;
	logic [AW-1:0]   cp_src_q;
	logic [DW-1:0]   cp_cnt_q;
	logic            cp_wv_s1;
	logic [AW-1:0]   cp_wa_s1;

	logic in_fire;
	logic full;
	logic empty;
	logic nd_bad;
	logic nd_low;
	logic cp_more;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign full     = 32'(fill_q) >= 32'(depth_q);
	assign empty    = (fill_q == '0);
	assign nd_bad   = (in_new_depth == 8'd0) || (32'(in_new_depth) > MAX_DEPTH);
	assign nd_low   = 32'(in_new_depth) < 32'(fill_q);
	assign cp_more  = 32'(cp_cnt_q) < 32'(fill_q);

	// The two halves of the memory alternate: a resize copies the held
	// entries from the live half into the other one, starting at slot zero.
	always_comb begin
		mem_wr_en   = (in_fire && (in_req == rrf_pkg::REQ_PUSH) && !full) || cp_wv_s1;
		mem_wr_addr = cp_wv_s1 ? {~bank_q, cp_wa_s1} : {bank_q, wr_slot_q};
		mem_wr_data = cp_wv_s1 ? mem_rd_data : in_payload[PAYLOAD_WIDTH-1:0];
		mem_rd_en   = (in_fire && (in_req == rrf_pkg::REQ_POP) && !empty)
			|| ((state_q == ST_COPY) && cp_more);
		mem_rd_addr = (state_q == ST_COPY) ? {bank_q, cp_src_q} : {bank_q, rd_slot_q};
	end

	assign res_valid        = (state_q == ST_EMIT);
	assign res.status       = status_q;
	assign res.load_now     = 8'(fill_q);
	assign res.depth_now    = 8'(depth_q);
	assign res.pushed_total = push_cnt_q;
	assign res.popped_total = pop_cnt_q;
	// The read data register holds until the next read, and no read is
	// issued while a result waits.
	assign res_payload      = pop_ok_q ? mem_rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bank_q     <= 1'b0;
			rd_slot_q  <= '0;
			wr_slot_q  <= '0;
			fill_q     <= '0;
			depth_q    <= clamp_depth(rrf_pkg::RESET_DEPTH);
			push_cnt_q <= '0;
			pop_cnt_q  <= '0;
			status_q   <= rrf_pkg::STAT_OK;
			pop_ok_q   <= 1'b0;
			nd_q       <= '0;
			cp_src_q   <= '0;
			cp_cnt_q   <= '0;
			cp_wv_s1   <= 1'b0;
			cp_wa_s1   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						status_q <= rrf_pkg::STAT_OK;
						pop_ok_q <= 1'b0;
						state_q  <= ST_EMIT;
						case (in_req)
							rrf_pkg::REQ_PUSH: begin
								if (full) begin
									status_q <= rrf_pkg::STAT_FULL;
								end else begin
									wr_slot_q  <= next_slot(wr_slot_q, depth_q);
									fill_q     <= fill_q + DW'(1);
									push_cnt_q <= push_cnt_q + 32'd1;
								end
							end
							rrf_pkg::REQ_POP: begin
								if (empty) begin
									status_q <= rrf_pkg::STAT_EMPTY;
								end else begin
									pop_ok_q  <= 1'b1;
									rd_slot_q <= next_slot(rd_slot_q, depth_q);
									fill_q    <= fill_q - DW'(1);
									pop_cnt_q <= pop_cnt_q + 32'd1;
								end
							end
							rrf_pkg::REQ_RESIZE: begin
								if (nd_bad) begin
									status_q <= rrf_pkg::STAT_RANGE;
								end else if (nd_low) begin
									status_q <= rrf_pkg::STAT_BELOW_LOAD;
								end else begin
									nd_q     <= DW'(in_new_depth);
									cp_src_q <= rd_slot_q;
									cp_cnt_q <= '0;
									state_q  <= ST_COPY;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_COPY: begin
					cp_wv_s1 <= cp_more;
					if (cp_more) begin
						cp_wa_s1 <= cp_cnt_q[AW-1:0];
						cp_src_q <= next_slot(cp_src_q, depth_q);
						cp_cnt_q <= cp_cnt_q + DW'(1);
					end else if (!cp_wv_s1) begin
						bank_q    <= ~bank_q;
						depth_q   <= nd_q;
						rd_slot_q <= '0;
						wr_slot_q <= (fill_q >= nd_q) ? '0 : fill_q[AW-1:0];
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// A depth write restarts the queue; send only while idle (unchecked).
			if (cfg_valid) begin
				rd_slot_q  <= '0;
				wr_slot_q  <= '0;
				fill_q     <= '0;
				push_cnt_q <= '0;
				pop_cnt_q  <= '0;
				depth_q    <= clamp_depth(cfg_data);
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_within_depth: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(depth_q))
		else $error("load exceeds active depth");

	a_read_slot_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rd_slot_q) < 32'(depth_q))
		else $error("read slot outside the active ring");

	a_no_write_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !mem_wr_en && !mem_rd_en)
		else $error("memory access while a result waits");

	a_pop_reaches_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_req == rrf_pkg::REQ_POP) && !empty && !cfg_valid)
		|=> (res_valid && pop_ok_q))
		else $error("successful pop did not produce its result");
`endif

endmodule

[design/resizable_ring_fifo.sv]
// Resizable ring FIFO of payload words.
// Requests arrive on the s_ channel (kind in s_tuser: push, pop or resize).
// Each request gives exactly one result on the m_ channel, with the status
// in m_tuser and the popped word, load, depth and both totals in m_tdata.
// A cfg write sets the active depth and restarts the queue (empty, totals
// cleared). Always ready; must be used only while idle (not enforced).
// A push or a pop makes its single memory access in the request cycle; the
// result then moves from the emit state to the output register.
// An accepted resize copies every held entry, one per cycle, through the
// memory's read port into the other half of the memory, then makes the last
// copy write and switches halves before the result moves out.
// Push, pop and refused requests go straight to the result; only an accepted
// resize copies first.
// After reset the queue is empty with depth 16 (at most MAX_DEPTH).
// When the receiver stalls, the result waits in the output register and one
// more request may be worked on; then s_tready stays low until space frees.
module resizable_ring_fifo #(
	parameter int unsigned MAX_DEPTH     = 128,
	parameter int unsigned PAYLOAD_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data,     // initial_depth
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,      // payload, new_depth
	input  logic [1:0]   s_tuser,      // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,      // popped_payload, load_now, depth_now,
	                                   // pushed_total, popped_total
	output logic [2:0]   m_tuser       // status
);

	localparam int unsigned AW = $clog2(MAX_DEPTH);

	logic                     res_valid;
	logic                     res_ready;
	rrf_pkg::rrf_res_t        res;
	logic [PAYLOAD_WIDTH-1:0] res_payload;
	logic                     mem_wr_en;
	logic [AW:0]              mem_wr_addr;
	logic [PAYLOAD_WIDTH-1:0] mem_wr_data;
	logic                     mem_rd_en;
	logic [AW:0]              mem_rd_addr;
	logic [PAYLOAD_WIDTH-1:0] mem_rd_data;

	logic                     m_tvalid_q;
	rrf_pkg::rrf_res_t        out_res_q;
	logic [63:0]              out_payload_q;

	assign cfg_ready = 1'b1;

	rrf_ctrl #(
		.MAX_DEPTH     (MAX_DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_req       (s_tuser),
		.in_payload   (s_tdata[63:0]),
		.in_new_depth (s_tdata[71:64]),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.res_payload  (res_payload),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data)
	);

	rrf_mem #(
		.ADDR_WIDTH (AW + 1),
		.DATA_WIDTH (PAYLOAD_WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q     <= res;
			out_payload_q <= 64'(res_payload);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_res_q.status;
	assign m_tdata  = {out_res_q.popped_total, out_res_q.pushed_total,
		out_res_q.depth_now, out_res_q.load_now, out_payload_q};

endmodule

[tb/sv/resizable_ring_fifo_tb.sv]
`timescale 1ns / 1ps

module resizable_ring_fifo_tb;

	localparam int unsigned MAX_DEPTH = 128;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned TAIL_CYCLES = MAX_DEPTH + 16;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] word;
		logic [7:0]  load;
		logic [7:0]  depth;
		logic [31:0] pushes;
		logic [31:0] pops;
	} fifo_reply_t;

	// Mirrors the queue and keeps the replies that are still due, oldest first.
	class fifo_ledger;
		logic [63:0] slots [MAX_DEPTH];
		int unsigned rd_slot;
		int unsigned wr_slot;
		int unsigned held;
		int unsigned depth;
		logic [31:0] push_cnt;
		logic [31:0] pop_cnt;
		fifo_reply_t due_results [$];
		int unsigned errors;
		int unsigned requests;
		int unsigned replies;
		int unsigned status_seen [8];

		function new();
			errors = 0;
			requests = 0;
			replies = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			restart(rrf_pkg::RESET_DEPTH);
		endfunction

		// A register write empties the queue and clamps the depth into range.
		function void restart(logic [7:0] cfg);
			rd_slot = 0;
			wr_slot = 0;
			held = 0;
			push_cnt = '0;
			pop_cnt = '0;
			if (cfg == 8'd0) begin
				depth = 1;
			end else if (cfg > MAX_DEPTH) begin
				depth = MAX_DEPTH;
			end else begin
				depth = cfg;
			end
		endfunction

		function int unsigned advance(int unsigned s);
			return (s + 1 >= depth) ? 0 : s + 1;
		endfunction

		function void note_request(logic [1:0] kind, logic [63:0] payload, logic [7:0] nd);
			fifo_reply_t r;
			logic [63:0] compacted [MAX_DEPTH];
			int unsigned s;
			r.status = rrf_pkg::STAT_OK;
			r.word = '0;
			case (kind)
				rrf_pkg::REQ_PUSH: begin
					if (held >= depth) begin
						r.status = rrf_pkg::STAT_FULL;
					end else begin
						slots[wr_slot] = payload;
						wr_slot = advance(wr_slot);
						held++;
						push_cnt++;
					end
				end
				rrf_pkg::REQ_POP: begin
					if (held == 0) begin
						r.status = rrf_pkg::STAT_EMPTY;
					end else begin
						r.word = slots[rd_slot];
						rd_slot = advance(rd_slot);
						held--;
						pop_cnt++;
					end
				end
				rrf_pkg::REQ_RESIZE: begin
					if (nd == 8'd0 || nd > MAX_DEPTH) begin
						r.status = rrf_pkg::STAT_RANGE;
					end else if (nd < held) begin
						r.status = rrf_pkg::STAT_BELOW_LOAD;
					end else begin
						// Entries are walked in order under the old depth, then
						// land from slot zero upward.
						s = rd_slot;
						for (int i = 0; i < held; i++) begin
							compacted[i] = slots[s];
							s = advance(s);
						end
						for (int i = 0; i < held; i++) slots[i] = compacted[i];
						depth = nd;
						rd_slot = 0;
						wr_slot = (held >= nd) ? 0 : held;
					end
				end
				default: ;
			endcase
			r.load = 8'(held);
			r.depth = 8'(depth);
			r.pushes = push_cnt;
			r.pops = pop_cnt;
			due_results.push_back(r);
			requests++;
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch on result %0d: %s", $time, replies, msg);
			errors++;
		endtask

		task check_result(fifo_reply_t got);
			fifo_reply_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result with no request waiting (status %0d)",
					got.status));
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.word !== want.word)
				report_mismatch($sformatf("popped word %h, expected %h", got.word, want.word));
			if (got.load !== want.load)
				report_mismatch($sformatf("load %0d, expected %0d", got.load, want.load));
			if (got.depth !== want.depth)
				report_mismatch($sformatf("depth %0d, expected %0d", got.depth, want.depth));
			if (got.pushes !== want.pushes)
				report_mismatch($sformatf("push total %0d, expected %0d",
					got.pushes, want.pushes));
			if (got.pops !== want.pops)
				report_mismatch($sformatf("pop total %0d, expected %0d", got.pops, want.pops));
			status_seen[want.status]++;
			replies++;
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;     // payload, new_depth
	logic [1:0]   s_tuser = '0;     // req_type
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;          // popped_payload, load_now, depth_now,
	                                // pushed_total, popped_total
	logic [2:0]   m_tuser;          // status

	fifo_ledger ledger;
	bit src_idle_on = 1'b0;
	bit sink_idle_on = 1'b0;
	bit hold_req = 1'b0;

	resizable_ring_fifo #(
		.MAX_DEPTH(MAX_DEPTH),
		.PAYLOAD_WIDTH(64)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && ledger != null) begin
			if (cfg_valid && cfg_ready) ledger.restart(cfg_data);
			if (s_tvalid && s_tready) ledger.note_request(s_tuser, s_tdata[63:0], s_tdata[71:64]);
			if (m_tvalid && m_tready)
				ledger.check_result({m_tuser, m_tdata[63:0], m_tdata[71:64], m_tdata[79:72],
					m_tdata[111:80], m_tdata[143:112]});
		end
	end

	// Result side: random stall bursts, or one long hold-off on request.
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("timeout: the block stopped making progress");
		$display("*** FAILED ***");
		$finish;
	end

	// Called and returning at a falling edge, after the transfer has been seen.
	task automatic send_request(input logic [1:0] kind, input logic [63:0] payload,
		input logic [7:0] nd);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {nd, payload};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_request(input int unsigned push_pct);
		logic [1:0] kind;
		logic [63:0] payload;
		logic [7:0] nd;
		int unsigned pick;
		int unsigned lo;
		pick = $urandom_range(0, 99);
		lo = (ledger.held == 0) ? 1 : ledger.held;
		nd = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 15))
			0: payload = '0;
			1: payload = '1;
			default: payload = {$urandom, $urandom};
		endcase
		if (pick < 3) begin
			kind = REQ_UNUSED;
		end else if (pick < 12) begin
			kind = rrf_pkg::REQ_RESIZE;
			case ($urandom_range(0, 9))
				0: nd = 8'd0;
				1: nd = 8'($urandom_range(MAX_DEPTH + 1, 255));
				2: nd = (ledger.held > 1) ? 8'($urandom_range(1, ledger.held - 1)) : 8'd0;
				3: nd = 8'(lo);
				4, 5: nd = 8'($urandom_range(lo, MAX_DEPTH));
				default: nd = 8'($urandom_range(lo, (lo + 6 > MAX_DEPTH) ? MAX_DEPTH : lo + 6));
			endcase
		end else if ($urandom_range(0, 99) < push_pct) begin
			kind = rrf_pkg::REQ_PUSH;
		end else begin
			kind = rrf_pkg::REQ_POP;
		end
		send_request(kind, payload, nd);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (ledger.due_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_depth(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Push-heavy and pop-heavy stretches alternate so the queue sweeps
	// between empty and full.
	task automatic run_random(input int unsigned count);
		int unsigned push_pct;
		push_pct = 80;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 39) push_pct = (push_pct == 80) ? 25 : 80;
			random_request(push_pct);
		end
	endtask

	initial begin
		ledger = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening at the reset depth.
		send_request(rrf_pkg::REQ_POP, '0, 8'd0);
		send_request(rrf_pkg::REQ_RESIZE, '0, 8'd0);
		send_request(rrf_pkg::REQ_RESIZE, '0, 8'd129);
		send_request(rrf_pkg::REQ_RESIZE, '1, 8'd255);
		send_request(rrf_pkg::REQ_PUSH, '0, 8'd0);
		send_request(rrf_pkg::REQ_PUSH, '1, 8'hff);
		send_request(rrf_pkg::REQ_PUSH, 64'ha5a5_5a5a_0f0f_f0f0, 8'd0);
		send_request(rrf_pkg::REQ_RESIZE, '0, 8'd2);
		send_request(rrf_pkg::REQ_RESIZE, '0, 8'd3);
		send_request(rrf_pkg::REQ_PUSH, 64'h1234_5678_9abc_def0, 8'd0);
		send_request(REQ_UNUSED, '1, 8'hff);
		send_request(rrf_pkg::REQ_POP, '0, 8'd0);
		send_request(rrf_pkg::REQ_PUSH, 64'h8000_0000_0000_0001, 8'd0);
		send_request(rrf_pkg::REQ_RESIZE, '0, 8'd128);
		send_request(rrf_pkg::REQ_POP, '0, 8'd0);
		send_request(rrf_pkg::REQ_POP, '0, 8'd0);
		send_request(rrf_pkg::REQ_POP, '0, 8'd0);
		send_request(rrf_pkg::REQ_POP, '0, 8'd0);
		send_request(rrf_pkg::REQ_RESIZE, '0, 8'd1);
		send_request(rrf_pkg::REQ_PUSH, 64'hdead_beef_cafe_f00d, 8'd0);
		send_request(rrf_pkg::REQ_PUSH, 64'h0123_4567_89ab_cdef, 8'd0);
		send_request(rrf_pkg::REQ_POP, '0, 8'd0);
		wait_drained();

		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		write_depth(8'd0);
		run_random(100);
		wait_drained();

		// The result side holds off while pushes keep coming, so the input stalls.
		write_depth(8'd255);
		run_random(100);
		hold_req = 1'b1;
		for (int n = 0; n < 50; n++) random_request(90);
		wait_drained();

		write_depth(8'd128);
		run_random(130);
		wait_drained();

		write_depth(8'd7);
		run_random(100);
		wait_drained();

		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		write_depth(8'd1);
		run_random(100);
		wait_drained();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (ledger.due_results.size() != 0)
			ledger.report_mismatch($sformatf("%0d results never arrived",
				ledger.due_results.size()));
		$display("Checked %0d results for %0d requests over six depth settings.",
			ledger.replies, ledger.requests);
		$display("Statuses ok/full/empty/range/below-load: %0d/%0d/%0d/%0d/%0d",
			ledger.status_seen[rrf_pkg::STAT_OK], ledger.status_seen[rrf_pkg::STAT_FULL],
			ledger.status_seen[rrf_pkg::STAT_EMPTY], ledger.status_seen[rrf_pkg::STAT_RANGE],
			ledger.status_seen[rrf_pkg::STAT_BELOW_LOAD]);
		if (ledger.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
